// ===== rtl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared types and codes of the binary-heap min priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int MODE_W   = 1;
  localparam int PRIO_W   = 16;
  localparam int TIE_W    = 8;
  localparam int PAY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] prio_key;
    logic [TIE_W-1:0]  tie_key;
    logic [PAY_W-1:0]  payload_tag;
  } cmd_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [TIE_W-1:0]    tie;
    logic [PAY_W-1:0]    payload;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP      = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_RD_ROOT = 9'b000001000,
    S_LAST    = 9'b000010000,
    S_DN_L    = 9'b000100000,
    S_DN_R    = 9'b001000000,
    S_DN_CMP  = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

endpackage

// ===== rtl/binary_heap_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_min_priority_queue
// min priority queue on a binary heap held in one ram
//
// channel | direction | tdata fields (lsb first)                  | tuser
// in_     | slave     | mode, prio_key, tie_key, payload_tag       | -
// out_    | master    | out_prio, out_tie, out_payload, status, occ | -
//
// insert climbs the heap with one ram read and one key compare per level;
// remove descends it with one ram read per child present and up to two key
// compares per level; all reads share the single read port.
// one item is worked on at a time; the next is taken once the previous
// result sits in the output register, even while that register stalls.
// synchronous active-low reset empties the heap at once; no clearing pass.
// ----------------------------------------------------------------------------
module binary_heap_min_priority_queue #(
  parameter int CAPACITY     = 64,
  parameter int PRIO_BITS    = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // mode, prio_key, tie_key, payload_tag, zero pad
  input  logic [bhpq_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_prio, out_tie, out_payload, status, occupancy, zero pad
  output logic [bhpq_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int EW = PRIO_BITS + bhpq_pkg::TIE_W + PAYLOAD_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int RES_W = $bits(bhpq_pkg::res_t);

  bhpq_pkg::cmd_t cmd;
  bhpq_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [EW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [bhpq_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  assign cmd.mode        = in_tdata[0];
  assign cmd.prio_key    = in_tdata[16:1];
  assign cmd.tie_key     = in_tdata[24:17];
  assign cmd.payload_tag = in_tdata[40:25];

  bhpq_ctrl #(
    .CAPACITY     (CAPACITY),
    .PRIO_BITS    (PRIO_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  bhpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {{(bhpq_pkg::OUT_TDATA_W - RES_W){1'b0}},
                      res.occupancy, res.status, res.payload, res.tie, res.prio};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhpq_ctrl
// sift sequencer: entry count, hole register and read-compare-write walk
// ----------------------------------------------------------------------------
module bhpq_ctrl #(
  parameter int CAPACITY     = 64,
  parameter int PRIO_BITS    = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                cmd_valid,
  output logic                                                cmd_ready,
  input  bhpq_pkg::cmd_t                                      cmd,
  output logic                                                res_valid,
  input  logic                                                res_ready,
  output bhpq_pkg::res_t                                      res,
  output logic                                                ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0]                         ram_wr_addr,
  output logic [PRIO_BITS+bhpq_pkg::TIE_W+PAYLOAD_BITS-1:0]   ram_wr_data,
  output logic                                                ram_rd_en,
  output logic [$clog2(CAPACITY)-1:0]                         ram_rd_addr,
  input  logic [PRIO_BITS+bhpq_pkg::TIE_W+PAYLOAD_BITS-1:0]   ram_rd_data
);

  localparam int EW = PRIO_BITS + bhpq_pkg::TIE_W + PAYLOAD_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic after_f(input logic [EW-1:0] a, input logic [EW-1:0] b);
    after_f = a[EW-1:PAYLOAD_BITS] > b[EW-1:PAYLOAD_BITS];
  endfunction

  bhpq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [EW-1:0]    x_r, x_nxt;
  logic [EW-1:0]    left_r, left_nxt;
  logic [EW-1:0]    top_r, top_nxt;
  logic             has_r_r, has_r_nxt;
  bhpq_pkg::res_t   res_r, res_nxt;

  logic [CW:0]   lc_w;
  logic [CW:0]   lc_m1_w;
  logic [CW:0]   lc_p1_w;
  logic [CW:0]   cnt_ext;
  logic [CW-1:0] km1_w;
  logic [CW-1:0] par_w;
  logic [CW-1:0] par_m1_w;
  logic          pick_right;
  logic [EW-1:0] child_w;
  logic          accept;

  assign lc_w       = {k_r, 1'b0};
  assign lc_m1_w    = lc_w - 1'b1;
  assign lc_p1_w    = lc_w + 1'b1;
  assign cnt_ext    = {1'b0, count_r};
  assign km1_w      = k_r - 1'b1;
  assign par_w      = k_r >> 1;
  assign par_m1_w   = par_w - 1'b1;
  assign pick_right = has_r_r && after_f(left_r, ram_rd_data);
  assign child_w    = pick_right ? ram_rd_data : left_r;

  assign cmd_ready = (state_r == bhpq_pkg::S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign res_valid = (state_r == bhpq_pkg::S_FIN);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    x_nxt       = x_r;
    left_nxt    = left_r;
    top_nxt     = top_r;
    has_r_nxt   = has_r_r;
    res_nxt     = res_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = km1_w[AW-1:0];
    ram_wr_data = x_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (cmd.mode == bhpq_pkg::MODE_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              res_nxt.status    = bhpq_pkg::STATUS_FULL;
              res_nxt.occupancy = bhpq_pkg::OCC_W'(count_r);
              state_nxt         = bhpq_pkg::S_FIN;
            end else begin
              x_nxt     = {PRIO_BITS'(cmd.prio_key), cmd.tie_key,
                           PAYLOAD_BITS'(cmd.payload_tag)};
              k_nxt     = count_r + 1'b1;
              count_nxt = count_r + 1'b1;
              state_nxt = bhpq_pkg::S_UP;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status    = bhpq_pkg::STATUS_EMPTY;
              res_nxt.occupancy = bhpq_pkg::OCC_W'(count_r);
              state_nxt         = bhpq_pkg::S_FIN;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              count_nxt   = count_r - 1'b1;
              state_nxt   = bhpq_pkg::S_RD_ROOT;
            end
          end
        end
      end
      bhpq_pkg::S_UP: begin
        if (k_r == CW'(1)) begin
          ram_wr_en         = 1'b1;
          res_nxt.status    = bhpq_pkg::STATUS_OK;
          res_nxt.occupancy = bhpq_pkg::OCC_W'(count_r);
          state_nxt         = bhpq_pkg::S_FIN;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = par_m1_w[AW-1:0];
          state_nxt   = bhpq_pkg::S_UP_CMP;
        end
      end
      bhpq_pkg::S_UP_CMP: begin
        ram_wr_en = 1'b1;
        if (after_f(ram_rd_data, x_r)) begin
          ram_wr_data = ram_rd_data;
          k_nxt       = par_w;
          state_nxt   = bhpq_pkg::S_UP;
        end else begin
          res_nxt.status    = bhpq_pkg::STATUS_OK;
          res_nxt.occupancy = bhpq_pkg::OCC_W'(count_r);
          state_nxt         = bhpq_pkg::S_FIN;
        end
      end
      bhpq_pkg::S_RD_ROOT: begin
        top_nxt     = ram_rd_data;
        ram_rd_en   = 1'b1;
        ram_rd_addr = count_r[AW-1:0];
        state_nxt   = bhpq_pkg::S_LAST;
      end
      bhpq_pkg::S_LAST: begin
        x_nxt     = ram_rd_data;
        k_nxt     = CW'(1);
        state_nxt = bhpq_pkg::S_DN_L;
      end
      bhpq_pkg::S_DN_L: begin
        if (lc_w > cnt_ext) begin
          ram_wr_en         = 1'b1;
          res_nxt.prio      = bhpq_pkg::PRIO_W'(top_r[EW-1 -: PRIO_BITS]);
          res_nxt.tie       = top_r[PAYLOAD_BITS +: bhpq_pkg::TIE_W];
          res_nxt.payload   = bhpq_pkg::PAY_W'(top_r[PAYLOAD_BITS-1:0]);
          res_nxt.status    = bhpq_pkg::STATUS_OK;
          res_nxt.occupancy = bhpq_pkg::OCC_W'(count_r);
          state_nxt         = bhpq_pkg::S_FIN;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = lc_m1_w[AW-1:0];
          has_r_nxt   = lc_w < cnt_ext;
          state_nxt   = bhpq_pkg::S_DN_R;
        end
      end
      bhpq_pkg::S_DN_R: begin
        left_nxt = ram_rd_data;
        if (has_r_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = lc_w[AW-1:0];
        end
        state_nxt = bhpq_pkg::S_DN_CMP;
      end
      bhpq_pkg::S_DN_CMP: begin
        ram_wr_en = 1'b1;
        if (after_f(x_r, child_w)) begin
          ram_wr_data = child_w;
          k_nxt       = pick_right ? lc_p1_w[CW-1:0] : lc_w[CW-1:0];
          state_nxt   = bhpq_pkg::S_DN_L;
        end else begin
          res_nxt.prio      = bhpq_pkg::PRIO_W'(top_r[EW-1 -: PRIO_BITS]);
          res_nxt.tie       = top_r[PAYLOAD_BITS +: bhpq_pkg::TIE_W];
          res_nxt.payload   = bhpq_pkg::PAY_W'(top_r[PAYLOAD_BITS-1:0]);
          res_nxt.status    = bhpq_pkg::STATUS_OK;
          res_nxt.occupancy = bhpq_pkg::OCC_W'(count_r);
          state_nxt         = bhpq_pkg::S_FIN;
        end
      end
      bhpq_pkg::S_FIN: begin
        if (res_ready) begin
          state_nxt = bhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhpq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    x_r     <= x_nxt;
    left_r  <= left_nxt;
    top_r   <= top_nxt;
    has_r_r <= has_r_nxt;
    res_r   <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("ram read and write in the same cycle");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.status == bhpq_pkg::STATUS_FULL)
      |-> res_r.occupancy == bhpq_pkg::OCC_W'(CAPACITY))
    else $error("full status without a full heap");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd.mode == bhpq_pkg::MODE_INSERT && count_r < CW'(CAPACITY))
      |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the heap");

endmodule
